// File: src/spd_pkg.sv
// Shared types and constants of the slotted page directory.
// Holds the operation, status and sequencer encodings and the directory entry layout.
// Depends on nothing.
package spd_pkg;

   localparam int MAX_SLOTS_DEF = 64;

   localparam int ID_W    = 16;
   localparam int BYTES_W = 17;
   localparam int USED_W  = 7;
   // two guard bits above an offset catch both underflow and overflow
   localparam int SUM_W   = BYTES_W + 2;

   localparam logic [BYTES_W-1:0] PAGE_BYTES_RST = BYTES_W'(4096);
   localparam logic [ID_W-1:0]    ID_MAX         = '1;
   localparam logic [ID_W-1:0]    ID_FIRST       = ID_W'(1);

   typedef enum logic [1:0] {
      MODE_CREATE = 2'd0,
      MODE_RESIZE = 2'd1,
      MODE_FREE   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NO_ROOM   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CREATE,
      ST_SCAN,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] offset;
      logic [BYTES_W-1:0] size;
   } entry_type;

endpackage

// File: src/spd_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/spd_shift_unit.sv
// Shared offset adder of the slot directory: base + plus - minus with range check.
// Depends on spd_pkg.
module spd_shift_unit import spd_pkg::*; (
   input  logic [BYTES_W-1:0] base,
   input  logic [BYTES_W-1:0] plus,
   input  logic [BYTES_W-1:0] minus,
   output logic [BYTES_W-1:0] sum,
   output logic               out_of_range
);

   logic [SUM_W-1:0] full;

   // modulo 2^SUM_W; any guard bit set means below zero or above the 17-bit limit
   assign full = SUM_W'(base) + SUM_W'(plus) - SUM_W'(minus);

   assign sum          = full[BYTES_W-1:0];
   assign out_of_range = (full[SUM_W-1:BYTES_W] != '0);

endmodule

// File: src/slotted_page_directory_core.sv
// Top level of the slotted page directory: sequencer, state and result register.
// Depends on spd_pkg, spd_ram and spd_shift_unit.
//
// Usage
//   Request beats (req_valid/req_ready) carry mode, target id and record size.
//   Each beat yields exactly one response beat (rsp_valid/rsp_ready) with the
//   status, the slot acted on, its offset, the new tail and the slot count.
//   csr_wr_en/csr_wr_data write the page size; write it only while idle.
// Timing
//   req_ready is high only when idle, so one request is in hand at a time.
//   Create passes through a create state before the finish state; mode 3 and
//   resize/free on an empty directory go straight to the finish state.
//   Resize/free: a pipelined search pass that also range-checks the shifted
//   offsets, a rewrite pass from the found slot on (skipped when the slot is
//   not found, on error or when the last slot is freed) and a commit in the
//   finish state. Both passes read one entry at a time through the single
//   read port of the entry memory.
// Reset
//   Synchronous; leaves an empty directory and a page size of 4096 bytes.
//   No clearing pass: entries at or above the count are never read.
// Stall
//   A finished response sits in the output register; the next request is
//   accepted meanwhile, but its response waits until the previous beat is taken.
module slotted_page_directory_core import spd_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [BYTES_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [ID_W-1:0]    req_target_id,
   input  logic [BYTES_W-1:0] req_record_bytes,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_result_id,
   output logic [BYTES_W-1:0] rsp_result_offset,
   output logic [BYTES_W-1:0] rsp_tail_offset,
   output logic [USED_W-1:0]  rsp_used_slots
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);

   // sequencer
   state_type state_ff, state_in;

   // architectural state
   logic [BYTES_W-1:0] page_bytes_ff, page_bytes_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [BYTES_W-1:0] tail_ff, tail_in;
   logic [ID_W-1:0]    last_id_ff, last_id_in;

   // request held for the duration of the operation
   mode_type           mode_ff, mode_in;
   logic [ID_W-1:0]    tid_ff, tid_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;

   // pass pipeline: read index and the index whose data is at the memory output
   logic [CW-1:0]      rd_ff, rd_in;
   logic               ev_vld_ff, ev_vld_in;
   logic [CW-1:0]      ev_idx_ff, ev_idx_in;

   // search results
   logic               found_ff, found_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               err_ff, err_in;
   logic [BYTES_W-1:0] plus_ff, plus_in;

   // operation result and captured new last entry
   status_type         stat_ff, stat_in;
   logic [ID_W-1:0]    rid_ff, rid_in;
   logic [BYTES_W-1:0] roff_ff, roff_in;
   logic [ID_W-1:0]    cap_id_ff, cap_id_in;
   logic [BYTES_W-1:0] cap_off_ff, cap_off_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [BYTES_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [BYTES_W-1:0] rsp_tail_ff, rsp_tail_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   // control and datapath wires
   logic               accept;
   logic               rsp_free;
   logic               issue;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   entry_type          ram_wr_data;
   entry_type          rd_entry;
   logic [CW-1:0]      last_idx;
   logic [CW-1:0]      prev_idx;
   logic [CW-1:0]      wr_idx;
   logic [BYTES_W-1:0] tail_now;
   logic [ID_W-1:0]    new_id;
   logic               id_overflow;
   logic               table_full;
   logic               resize_op;
   logic               free_op;
   logic               match_now;
   logic               ev_last;
   logic               check_now;
   logic               err_now;
   logic               found_fin;
   logic               err_fin;
   logic [CW-1:0]      pos_fin;
   logic [BYTES_W-1:0] unit_base;
   logic [BYTES_W-1:0] unit_plus;
   logic [BYTES_W-1:0] unit_minus;
   logic [BYTES_W-1:0] unit_sum;
   logic               unit_oor;

   // ---------------------------------------------------------------------
   // Entry memory and shared offset unit
   // ---------------------------------------------------------------------
   spd_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_SLOTS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   spd_shift_unit u_shift (
      .base         (unit_base),
      .plus         (unit_plus),
      .minus        (unit_minus),
      .sum          (unit_sum),
      .out_of_range (unit_oor)
   );

   // ---------------------------------------------------------------------
   // Common decode
   // ---------------------------------------------------------------------
   assign accept      = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign resize_op   = (mode_ff == MODE_RESIZE);
   assign free_op     = (mode_ff == MODE_FREE);
   assign last_idx    = count_ff - CW'(1);
   assign prev_idx    = count_ff - CW'(2);
   assign tail_now    = (count_ff == '0) ? page_bytes_ff : tail_ff;
   assign new_id      = (count_ff == '0) ? ID_FIRST : last_id_ff + ID_W'(1);
   assign id_overflow = (count_ff != '0) && (last_id_ff == ID_MAX);
   assign table_full  = (count_ff >= CW'(MAX_SLOTS));

   // first id hit in the scan; ids are unique so the first is the only one
   assign match_now = ev_vld_ff && !found_ff && (rd_entry.id == tid_ff);
   assign ev_last   = ev_vld_ff && (ev_idx_ff == last_idx);

   // resize checks the found slot and everything after; free only what follows
   assign check_now = ev_vld_ff && (found_ff || (match_now && resize_op));
   assign err_now   = check_now && unit_oor;
   assign found_fin = found_ff || match_now;
   assign err_fin   = err_ff || err_now;
   assign pos_fin   = found_ff ? pos_ff : ev_idx_ff;

   // free writes each entry one place lower than it was read
   assign wr_idx = free_op ? ev_idx_ff - CW'(1) : ev_idx_ff;

   // operand selection for the shared unit
   always_comb begin
      unit_minus = free_op ? '0 : bytes_ff;
      if (state_ff == ST_CREATE) begin
         unit_base = tail_now;
         unit_plus = '0;
      end else begin
         unit_base = rd_entry.offset;
         unit_plus = found_ff ? plus_ff : rd_entry.size;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_CREATE: state_in = ST_CREATE;
                  MODE_RESIZE,
                  MODE_FREE:   state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_CREATE: state_in = ST_FINISH;
         ST_SCAN: begin
            if (ev_last) begin
               if (!found_fin || err_fin) begin
                  state_in = ST_FINISH;
               end else if (free_op && (pos_fin == last_idx)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (ev_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs to the memory
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      issue       = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_idx[AW-1:0];
      ram_wr_data = '{id: rd_entry.id, offset: unit_sum, size: rd_entry.size};
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CREATE: begin
            ram_wr_en   = !table_full && !id_overflow && !unit_oor;
            ram_wr_addr = count_ff[AW-1:0];
            ram_wr_data = '{id: new_id, offset: unit_sum, size: bytes_ff};
         end
         ST_SCAN: issue = (rd_ff < count_ff);
         ST_WRITE: begin
            issue     = (rd_ff < count_ff);
            ram_wr_en = ev_vld_ff;
            if (resize_op && (ev_idx_ff == pos_ff)) begin
               ram_wr_data.size = bytes_ff;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   always_comb begin
      logic [CW-1:0]      new_count;
      logic [BYTES_W-1:0] new_tail;
      logic [31:0]        used_wide;

      page_bytes_in = csr_wr_en ? csr_wr_data : page_bytes_ff;
      count_in      = count_ff;
      tail_in       = tail_ff;
      last_id_in    = last_id_ff;
      mode_in       = mode_ff;
      tid_in        = tid_ff;
      bytes_in      = bytes_ff;
      rd_in         = rd_ff;
      ev_vld_in     = 1'b0;
      ev_idx_in     = ev_idx_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      err_in        = err_ff;
      plus_in       = plus_ff;
      stat_in       = stat_ff;
      rid_in        = rid_ff;
      roff_in       = roff_ff;
      cap_id_in     = cap_id_ff;
      cap_off_in    = cap_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_used_in   = rsp_used_ff;
      new_count     = count_ff;
      new_tail      = tail_ff;
      used_wide     = '0;

      // advance the read pipeline on every issued read
      if (issue) begin
         rd_in     = rd_ff + CW'(1);
         ev_vld_in = 1'b1;
         ev_idx_in = rd_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = mode_type'(req_mode);
               tid_in   = req_target_id;
               bytes_in = req_record_bytes;
               rd_in    = '0;
               found_in = 1'b0;
               err_in   = 1'b0;
               rid_in   = '0;
               roff_in  = '0;
               stat_in  = STAT_OK;
               if ((mode_type'(req_mode) == MODE_RESIZE ||
                    mode_type'(req_mode) == MODE_FREE) && (count_ff == '0)) begin
                  stat_in = STAT_NOT_FOUND;
               end
            end
         end
         ST_CREATE: begin
            if (table_full) begin
               stat_in = STAT_FULL;
            end else if (id_overflow || unit_oor) begin
               stat_in = STAT_NO_ROOM;
            end else begin
               rid_in     = new_id;
               roff_in    = unit_sum;
               cap_id_in  = new_id;
               cap_off_in = unit_sum;
            end
         end
         ST_SCAN: begin
            if (match_now) begin
               found_in = 1'b1;
               pos_in   = ev_idx_ff;
               plus_in  = rd_entry.size;
            end
            if (err_now) begin
               err_in = 1'b1;
            end
            // keep the entry that becomes last when the final slot is freed
            if (ev_vld_ff && (ev_idx_ff == prev_idx)) begin
               cap_id_in  = rd_entry.id;
               cap_off_in = rd_entry.offset;
            end
            if (ev_last) begin
               if (!found_fin) begin
                  stat_in = STAT_NOT_FOUND;
               end else if (err_fin) begin
                  stat_in = STAT_NO_ROOM;
               end else begin
                  rid_in = tid_ff;
                  rd_in  = free_op ? pos_fin + CW'(1) : pos_fin;
               end
            end
         end
         ST_WRITE: begin
            if (ev_vld_ff && resize_op && (ev_idx_ff == pos_ff)) begin
               roff_in = unit_sum;
            end
            // the last source entry lands as the new last slot
            if (ev_last) begin
               cap_id_in  = rd_entry.id;
               cap_off_in = unit_sum;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               if (stat_ff == STAT_OK) begin
                  case (mode_ff)
                     MODE_CREATE: begin
                        new_count  = count_ff + CW'(1);
                        new_tail   = cap_off_ff;
                        last_id_in = cap_id_ff;
                     end
                     MODE_RESIZE: new_tail = cap_off_ff;
                     MODE_FREE: begin
                        new_count  = count_ff - CW'(1);
                        new_tail   = cap_off_ff;
                        last_id_in = cap_id_ff;
                     end
                     default: ;
                  endcase
               end
               count_in      = new_count;
               tail_in       = new_tail;
               used_wide     = 32'(new_count);
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_id_in     = rid_ff;
               rsp_offset_in = roff_ff;
               rsp_tail_in   = (new_count == '0) ? page_bytes_ff : new_tail;
               rsp_used_in   = used_wide[USED_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_bytes_ff <= PAGE_BYTES_RST;
         count_ff      <= '0;
         ev_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_bytes_ff <= page_bytes_in;
         count_ff      <= count_in;
         ev_vld_ff     <= ev_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      tail_ff       <= tail_in;
      last_id_ff    <= last_id_in;
      mode_ff       <= mode_in;
      tid_ff        <= tid_in;
      bytes_ff      <= bytes_in;
      rd_ff         <= rd_in;
      ev_idx_ff     <= ev_idx_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      err_ff        <= err_in;
      plus_ff       <= plus_in;
      stat_ff       <= stat_in;
      rid_ff        <= rid_in;
      roff_ff       <= roff_in;
      cap_id_ff     <= cap_id_in;
      cap_off_ff    <= cap_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_tail_ff   <= rsp_tail_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_result_offset = rsp_offset_ff;
   assign rsp_tail_offset   = rsp_tail_ff;
   assign rsp_used_slots    = rsp_used_ff;

endmodule

// File: dv/slotted_page_directory_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for slotted_page_directory_core: directed table, then random
// phases per page size and a full-table phase. Depends on spd_pkg and the core RTL only.
module slotted_page_directory_core_tb;
   import spd_pkg::*;

   localparam int     MAX_SLOTS    = MAX_SLOTS_DEF;
   localparam longint PAGE_MAX     = 65536;
   localparam longint OFFSET_CEIL  = (64'd1 << BYTES_W) - 1;
   localparam int     SETTLE_GAP   = 8;
   localparam int     CYCLE_LIMIT  = 5_000_000;
   // mode 3 has no operation behind it; the block must answer it with a plain ok
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    id;
      logic [BYTES_W-1:0] offset;
      logic [BYTES_W-1:0] tail;
      logic [USED_W-1:0]  used;
   } slot_report_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [ID_W-1:0]    tid;
      logic [BYTES_W-1:0] nbytes;
      logic               typed;
      slot_report_type    want;
   } directed_row_type;

   localparam slot_report_type BLANK_REPORT = '{STAT_OK, '0, '0, '0, '0};

   // Opening sequence at the reset page size of 4096. Rows with typed set carry their
   // answer; the rest are left to the directory predictor.
   localparam directed_row_type DIRECTED_ROWS [22] = '{
      // empty directory: nothing to find, no room beyond the page
      '{MODE_FREE,   16'd1,     17'd0,     1'b1, '{STAT_NOT_FOUND, 16'd0, 17'd0, 17'd4096, 7'd0}},
      '{MODE_RESIZE, 16'd0,     17'd65536, 1'b1, '{STAT_NOT_FOUND, 16'd0, 17'd0, 17'd4096, 7'd0}},
      '{MODE_CREATE, 16'd0,     17'd4097,  1'b1, '{STAT_NO_ROOM,   16'd0, 17'd0, 17'd4096, 7'd0}},
      // fill the page exactly, then a zero-sized record on top
      '{MODE_CREATE, 16'd9,     17'd4096,  1'b1, '{STAT_OK,        16'd1, 17'd0, 17'd0,    7'd1}},
      '{MODE_CREATE, 16'hFFFF,  17'd0,     1'b1, '{STAT_OK,        16'd2, 17'd0, 17'd0,    7'd2}},
      '{MODE_CREATE, 16'd0,     17'd1,     1'b1, '{STAT_NO_ROOM,   16'd0, 17'd0, 17'd0,    7'd2}},
      // shrink the first slot to nothing: both slots move up to the page end
      '{MODE_RESIZE, 16'd1,     17'd0,     1'b1, '{STAT_OK,        16'd1, 17'd4096, 17'd4096, 7'd2}},
      // growing one byte past offset zero must be refused
      '{MODE_RESIZE, 16'd2,     17'd4097,  1'b1, '{STAT_NO_ROOM,   16'd0, 17'd0, 17'd4096, 7'd2}},
      '{MODE_RESIZE, 16'd2,     17'd4096,  1'b1, '{STAT_OK,        16'd2, 17'd0, 17'd0,    7'd2}},
      '{MODE_UNUSED, 16'hFFFF,  17'd65536, 1'b1, '{STAT_OK,        16'd0, 17'd0, 17'd0,    7'd2}},
      '{MODE_FREE,   16'd1,     17'd65536, 1'b1, '{STAT_OK,        16'd1, 17'd0, 17'd0,    7'd1}},
      '{MODE_FREE,   16'd2,     17'd0,     1'b1, '{STAT_OK,        16'd2, 17'd0, 17'd4096, 7'd0}},
      // ids restart at one once the directory is empty
      '{MODE_CREATE, 16'hAAAA,  17'd100,   1'b1, '{STAT_OK,        16'd1, 17'd3996, 17'd3996, 7'd1}},
      '{MODE_CREATE, 16'h5555,  17'd65536, 1'b1, '{STAT_NO_ROOM,   16'd0, 17'd0, 17'd3996, 7'd1}},
      '{MODE_CREATE, 16'd0,     17'd200,   1'b1, '{STAT_OK,        16'd2, 17'd3796, 17'd3796, 7'd2}},
      '{MODE_CREATE, 16'd0,     17'd300,   1'b1, '{STAT_OK,        16'd3, 17'd3496, 17'd3496, 7'd3}},
      '{MODE_RESIZE, 16'd2,     17'd50,    1'b0, BLANK_REPORT},
      '{MODE_FREE,   16'd1,     17'd1,     1'b0, BLANK_REPORT},
      '{MODE_RESIZE, 16'hFFFF,  17'd1,     1'b0, BLANK_REPORT},
      '{MODE_FREE,   16'hFFFF,  17'd0,     1'b0, BLANK_REPORT},
      '{MODE_CREATE, 16'h5555,  17'd0,     1'b0, BLANK_REPORT},
      '{MODE_RESIZE, 16'd3,     17'd0,     1'b0, BLANK_REPORT}
   };

   // Clock, reset and every block input start at known values.
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_wr_en        = 1'b0;
   logic [BYTES_W-1:0] csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode         = '0;
   logic [ID_W-1:0]    req_target_id    = '0;
   logic [BYTES_W-1:0] req_record_bytes = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic [1:0]         rsp_status;
   logic [ID_W-1:0]    rsp_result_id;
   logic [BYTES_W-1:0] rsp_result_offset;
   logic [BYTES_W-1:0] rsp_tail_offset;
   logic [USED_W-1:0]  rsp_used_slots;

   // Shadow copy of the directory, kept in slot-id order like the block's own.
   logic [ID_W-1:0]    dir_ids   [MAX_SLOTS];
   logic [BYTES_W-1:0] dir_offs  [MAX_SLOTS];
   logic [BYTES_W-1:0] dir_sizes [MAX_SLOTS];
   int                 dir_count = 0;
   logic [BYTES_W-1:0] page_size = PAGE_BYTES_RST;

   slot_report_type pending_reports [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              sink_hold      = 0;

   slotted_page_directory_core #(.MAX_SLOTS(MAX_SLOTS)) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_target_id     (req_target_id),
      .req_record_bytes  (req_record_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_offset (rsp_result_offset),
      .rsp_tail_offset   (rsp_tail_offset),
      .rsp_used_slots    (rsp_used_slots)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Directory predictor
   // ---------------------------------------------------------------------------------------

   // Lowest record offset: the last slot's, or the page end when empty.
   function automatic logic [BYTES_W-1:0] dir_tail();
      return (dir_count == 0) ? page_size : dir_offs[dir_count-1];
   endfunction

   function automatic int find_slot(logic [ID_W-1:0] id);
      for (int i = 0; i < dir_count; i++)
         if (dir_ids[i] == id) return i;
      return -1;
   endfunction

   // Move slots from..count-1 by delta, all or none: refuse if any offset would leave
   // the 17-bit range.
   function automatic bit shift_entries(int from, longint delta);
      longint moved;
      for (int i = from; i < dir_count; i++) begin
         moved = longint'(dir_offs[i]) + delta;
         if (moved < 0 || moved > OFFSET_CEIL) return 1'b0;
      end
      for (int i = from; i < dir_count; i++)
         dir_offs[i] = BYTES_W'(longint'(dir_offs[i]) + delta);
      return 1'b1;
   endfunction

   // Apply one request to the shadow directory and return the response it must produce.
   // Any refused request leaves the directory as it was and reports id and offset 0.
   function automatic slot_report_type compute_slot_op(logic [1:0] mode,
                                                       logic [ID_W-1:0] tid,
                                                       logic [BYTES_W-1:0] nbytes);
      slot_report_type    rep;
      logic [BYTES_W-1:0] tail;
      logic [ID_W:0]      next_id;
      int                 pos;
      rep  = BLANK_REPORT;
      tail = dir_tail();
      case (mode)
         MODE_CREATE: begin
            // one guard bit above the id shows the overflow past the largest id
            next_id = (dir_count == 0) ? (ID_W+1)'(1) : {1'b0, dir_ids[dir_count-1]} + 1'b1;
            if (dir_count >= MAX_SLOTS) begin
               rep.status = STAT_FULL;
            end else if (next_id > {1'b0, ID_MAX} || nbytes > tail) begin
               rep.status = STAT_NO_ROOM;
            end else begin
               dir_ids[dir_count]   = next_id[ID_W-1:0];
               dir_offs[dir_count]  = tail - nbytes;
               dir_sizes[dir_count] = nbytes;
               dir_count++;
               rep.id     = next_id[ID_W-1:0];
               rep.offset = tail - nbytes;
            end
         end
         MODE_RESIZE: begin
            pos = find_slot(tid);
            if (pos < 0) begin
               rep.status = STAT_NOT_FOUND;
            end else if (!shift_entries(pos, longint'(dir_sizes[pos]) - longint'(nbytes))) begin
               rep.status = STAT_NO_ROOM;
            end else begin
               dir_sizes[pos] = nbytes;
               rep.id         = tid;
               rep.offset     = dir_offs[pos];
            end
         end
         MODE_FREE: begin
            pos = find_slot(tid);
            if (pos < 0) begin
               rep.status = STAT_NOT_FOUND;
            end else if (!shift_entries(pos + 1, longint'(dir_sizes[pos]))) begin
               rep.status = STAT_NO_ROOM;
            end else begin
               // close the gap: later slots move down one place
               for (int i = pos; i < dir_count - 1; i++) begin
                  dir_ids[i]   = dir_ids[i+1];
                  dir_offs[i]  = dir_offs[i+1];
                  dir_sizes[i] = dir_sizes[i+1];
               end
               dir_count--;
               rep.id = tid;
            end
         end
         default: ;
      endcase
      rep.tail = dir_tail();
      rep.used = USED_W'(dir_count);
      return rep;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Present one request beat after a random gap and hold it until accepted. On the
   // accepting edge, log the expected response: the typed one for directed rows with an
   // answer, the predictor's otherwise (the predictor advances in both cases).
   task automatic issue(logic [1:0] mode, logic [ID_W-1:0] tid, logic [BYTES_W-1:0] nbytes,
                        logic typed, slot_report_type want);
      int              gap;
      slot_report_type predicted;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_target_id    <= tid;
      req_record_bytes <= nbytes;
      do @(posedge clock); while (!req_ready);
      predicted = compute_slot_op(mode, tid, nbytes);
      pending_reports.push_back(typed ? want : predicted);
   endtask

   // Drop valid, wait for every outstanding response, then let the block run quiet.
   task automatic settle(int cycles);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   // Empty the directory in random order so that the page size takes effect again.
   task automatic drain_directory();
      while (dir_count > 0)
         issue(MODE_FREE, dir_ids[$urandom_range(0, dir_count - 1)],
               BYTES_W'($urandom_range(0, PAGE_MAX)), 1'b0, BLANK_REPORT);
   endtask

   // One random request, mostly aimed at slots that exist and at sizes near the edges
   // of what fits, with some noise ids and sizes of any value.
   task automatic issue_random(int create_weight);
      int              pick, shape, pos;
      logic [1:0]      mode;
      logic [ID_W-1:0] tid;
      longint          nb, tail, grow_room;
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      tail  = longint'(dir_tail());
      tid   = ID_W'($urandom);
      pos   = (dir_count > 0) ? $urandom_range(0, dir_count - 1) : -1;
      if (pos >= 0 && $urandom_range(0, 6) != 0) tid = dir_ids[pos];
      if (pick >= 97) mode = MODE_UNUSED;
      else if (pick < create_weight) mode = MODE_CREATE;
      else if (pick < create_weight + (97 - create_weight) / 2) mode = MODE_RESIZE;
      else mode = MODE_FREE;
      nb = $urandom_range(0, PAGE_MAX);
      if (mode == MODE_CREATE) begin
         if (shape < 6) nb = $urandom_range(0, tail / 12 + 1);
         else if (shape == 6) nb = tail;        // exact fit
         else if (shape == 7) nb = tail + 1;    // one byte too many
      end else if (mode == MODE_RESIZE && pos >= 0) begin
         // the last slot's offset is the most that the chosen slot may grow by
         grow_room = longint'(dir_sizes[pos]) + longint'(dir_offs[dir_count-1]);
         if (shape < 6) nb = $urandom_range(0, 2 * longint'(dir_sizes[pos]) + 16);
         else if (shape == 6) nb = grow_room;
         else if (shape == 7) nb = grow_room + 1;
      end
      if (nb > PAGE_MAX) nb = PAGE_MAX;
      issue(mode, tid, BYTES_W'(nb), 1'b0, BLANK_REPORT);
   endtask

   // Set a new page size while idle, empty the directory and run random traffic.
   task automatic run_phase(longint page, int items, int create_weight);
      settle(SETTLE_GAP);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= BYTES_W'(page);
      @(posedge clock);
      page_size = BYTES_W'(page);
      csr_wr_en <= 1'b0;
      drain_directory();
      repeat (items) issue_random(create_weight);
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------------

   function automatic void check_field(string what, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic check_response();
      slot_report_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t ns: response beat with no request outstanding, expected none, actual "
                  , $time, "status %0d id %0d", rsp_status, rsp_result_id);
         mismatch_count++;
      end else begin
         want = pending_reports.pop_front();
         check_field("status",        want.status, rsp_status);
         check_field("result_id",     want.id,     rsp_result_id);
         check_field("result_offset", want.offset, rsp_result_offset);
         check_field("tail_offset",   want.tail,   rsp_tail_offset);
         check_field("used_slots",    want.used,   rsp_used_slots);
      end
   endtask

   // Check each response beat against the oldest expectation, then hold ready low for a
   // random number of cycles before the next beat.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         check_response();
         sink_hold = $urandom_range(0, 8);
         rsp_ready <= (sink_hold == 0);
      end else if (!rsp_ready) begin
         if (sink_hold > 0) sink_hold--;
         rsp_ready <= (sink_hold == 0);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Run sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset page size
      foreach (DIRECTED_ROWS[i])
         issue(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].tid, DIRECTED_ROWS[i].nbytes,
               DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // random traffic over a spread of page sizes, the extremes first
      run_phase(1, 55, 45);
      run_phase(PAGE_MAX, 55, 45);
      run_phase($urandom_range(1, PAGE_MAX), 55, 45);

      // fill the table past its limit, then work on a full directory
      run_phase(PAGE_BYTES_RST, 0, 0);
      repeat (MAX_SLOTS + 2)
         issue(MODE_CREATE, ID_W'($urandom), BYTES_W'($urandom_range(0, 60)), 1'b0,
               BLANK_REPORT);
      repeat (50) issue_random(30);

      run_phase($urandom_range(1, 200), 55, 45);

      // let the block run quiet so that any stray beat shows
      settle(2 * MAX_SLOTS + 8);
      if (mismatch_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
